// ===== hdl/trkb_pkg.sv =====
package trkb_pkg;

  // Pointer event kinds
  localparam logic [1:0] KIND_PAN_SET  = 2'd0;
  localparam logic [1:0] KIND_PAN      = 2'd1;
  localparam logic [1:0] KIND_SPIN_SET = 2'd2;
  localparam logic [1:0] KIND_SPIN     = 2'd3;

  // Result kinds
  localparam logic RES_PAN  = 1'b0;
  localparam logic RES_SPIN = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_VIEW_W = 2'd0;
  localparam logic [1:0] CFG_VIEW_H = 2'd1;
  localparam logic [1:0] CFG_COS    = 2'd2;
  localparam logic [1:0] CFG_SIN    = 2'd3;

  // Shared divide / square root unit
  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_op_t;

  typedef struct packed {
    logic       start;
    ds_op_t     op;
    logic [5:0] steps;
  } ds_req_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_NXG, ST_NXW, ST_NYG, ST_NYW,
    ST_DISP,
    ST_R2A, ST_R2B, ST_R2C,
    ST_ZG, ST_ZW, ST_HG, ST_HW,
    ST_LIFT,
    ST_CR0, ST_CR1, ST_CR2, ST_CR3, ST_CR4, ST_CR5, ST_CR6,
    ST_SM0, ST_SM1, ST_SM2, ST_SM3,
    ST_SHF, ST_SQ,
    ST_NG, ST_NW,
    ST_QG, ST_QW,
    ST_FIN
  } st_t;

endpackage

// ===== hdl/trkb_divsqrt.sv =====
module trkb_divsqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  trkb_pkg::ds_req_t req,
  input  logic [63:0]      opa,
  input  logic [31:0]      divisor,
  output logic             busy,
  output logic             done,
  output logic [47:0]      res
);
  import trkb_pkg::*;

  logic [33:0] rem_r;
  logic [47:0] acc_r;
  logic [63:0] dat_r;
  logic [31:0] dvs_r;
  ds_op_t      op_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [33:0] rem_s;
  logic [33:0] trial;
  logic [33:0] diff;
  logic [63:0] dat_sh;
  logic        ge;

  // One restoring step: shift in one bit (divide) or two bits (root)
  always_comb begin
    if (op_r == DS_DIV) begin
      rem_s  = {rem_r[32:0], dat_r[63]};
      trial  = {2'b00, dvs_r};
      dat_sh = {dat_r[62:0], 1'b0};
    end else begin
      rem_s  = {rem_r[31:0], dat_r[63:62]};
      trial  = {acc_r[31:0], 2'b01};
      dat_sh = {dat_r[61:0], 2'b00};
    end
    ge   = (rem_s >= trial);
    diff = rem_s - trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      acc_r <= '0;
      dat_r <= opa;
      dvs_r <= divisor;
      op_r  <= req.op;
    end else if (busy_r) begin
      rem_r <= ge ? diff : rem_s;
      acc_r <= {acc_r[46:0], ge};
      dat_r <= dat_sh;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = acc_r;

endmodule

// ===== hdl/trkb_mul.sv =====
module trkb_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  // Registered signed product
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ===== hdl/trackball_rotation_and_pan.sv =====
// Trackball rotation and pan engine.
// Input channel (in_valid / in_stall): one pointer event per transaction,
// in_kind selects set pan anchor, pan, set rotate anchor or rotate.
// Result channel (out_valid / out_stall): one transaction for pan and rotate
// events, none for the two anchor events. Pan results carry delta_x/y and
// zero quaternion; rotate results carry the unit quaternion and zero deltas.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write it only while no event is in flight.
// One event at a time: in_stall is high from acceptance until the sequencer
// is back in idle. Everything runs through one shared bit-serial
// divide/square-root unit and one registered 33x33 multiplier.
// Pan events run two divisions; rotate events take longest, and the four
// quaternion divisions dominate them (skipped if the quaternion is all zero).
// A finished result sits in the output register; a stalled receiver only
// holds the sequencer in its final state, the next event is taken after.
// Reset (rst_n, synchronous) restores window size 1x1, identity angle and
// zero anchors, and empties the output register.
module trackball_rotation_and_pan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [14:0] in_pos_x,
  input  logic signed [14:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic signed [15:0] out_delta_x,
  output logic signed [15:0] out_delta_y,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import trkb_pkg::*;

  function automatic logic signed [15:0] sat_q(input logic neg, input logic [47:0] q);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > 48'd32768) ? -16'sd32768 : 16'(16'd0 - q[15:0]);
    end else begin
      r = (q > 48'd32767) ? 16'sd32767 : q[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat17(input logic signed [16:0] d);
    logic signed [15:0] r;
    if (d > 17'sd32767) begin
      r = 16'sd32767;
    end else if (d < -17'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = d[15:0];
    end
    return r;
  endfunction

  st_t state_r, state_nxt;

  // Configuration registers
  logic [13:0]        vw_r, vh_r;
  logic signed [15:0] hc_r, hs_r;

  // Working registers
  logic [1:0]         kind_r;
  logic signed [14:0] px_r, py_r;
  logic signed [15:0] nx_r, ny_r, z_r;
  logic signed [15:0] pax_r, pay_r, sax_r, say_r, saz_r;
  logic               sph_r;
  logic [63:0]        acc_r;
  logic signed [32:0] tmp_r;
  logic signed [32:0] cr_r [3];
  logic [47:0]        mag_r [4];
  logic [3:0]         neg_r;
  logic signed [15:0] q_r [4];
  logic signed [15:0] dx_r, dy_r;
  logic [2:0]         idx_r;
  logic [30:0]        nrm_r;

  // Output register
  logic               out_valid_r;
  logic               okind_r;
  logic signed [15:0] odx_r, ody_r, oqw_r, oqx_r, oqy_r, oqz_r;

  // Shared units
  ds_req_t            ds_req;
  logic [63:0]        ds_opa;
  logic [31:0]        ds_dvs;
  logic               ds_busy, ds_done;
  logic [47:0]        ds_res;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  trkb_divsqrt u_ds (
    .clk(clk), .rst_n(rst_n), .req(ds_req), .opa(ds_opa), .divisor(ds_dvs),
    .busy(ds_busy), .done(ds_done), .res(ds_res)
  );

  trkb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  // Normalization operands
  logic [13:0]        wq, hq;
  logic signed [16:0] tx, ty;
  logic [16:0]        tmx, tmy;
  logic [29:0]        numx, numy;
  logic               out_free;
  logic               hi30, hi29, allz;
  logic [47:0]        pv;
  logic               pneg;
  logic [47:0]        pmag;
  logic [16:0]        habs;
  logic [44:0]        qnum;
  logic [36:0]        hnum;
  logic [24:0]        sv;

  always_comb begin
    wq   = (vw_r == 14'd0) ? 14'd1 : vw_r;
    hq   = (vh_r == 14'd0) ? 14'd1 : vh_r;
    tx   = {px_r[14], px_r, 1'b0} - {3'b000, wq};
    ty   = {3'b000, hq} - {py_r[14], py_r, 1'b0};
    tmx  = tx[16] ? 17'(17'd0 - tx) : tx;
    tmy  = ty[16] ? 17'(17'd0 - ty) : ty;
    numx = {tmx, 13'd0} + {16'd0, wq};
    numy = {tmy, 13'd0} + {16'd0, hq};
    out_free = !out_valid_r || !out_stall;
    hi30 = (|mag_r[0][47:30]) | (|mag_r[1][47:30]) | (|mag_r[2][47:30]) |
           (|mag_r[3][47:30]);
    hi29 = (|mag_r[0][47:29]) | (|mag_r[1][47:29]) | (|mag_r[2][47:29]) |
           (|mag_r[3][47:29]);
    allz = (mag_r[0] == 48'd0) && (mag_r[1] == 48'd0) &&
           (mag_r[2] == 48'd0) && (mag_r[3] == 48'd0);
    pv   = prod_r[47:0];
    pneg = prod_r[65];
    pmag = pneg ? 48'(48'd0 - pv) : pv;
    habs = hc_r[15] ? 17'(17'd0 - {hc_r[15], hc_r}) : {hc_r[15], hc_r};
    qnum = {1'b0, mag_r[idx_r[1:0]][29:0], 14'd0} + {15'd0, nrm_r[30:1]};
    hnum = {1'b1, 36'd0} + {6'd0, nrm_r};
    sv   = 25'(25'd16777216 - acc_r[24:0]);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and shared-unit operands
  always_comb begin
    state_nxt = state_r;
    ds_req    = '{start: 1'b0, op: DS_DIV, steps: 6'd0};
    ds_opa    = '0;
    ds_dvs    = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_NXG;
      end
      ST_NXG: begin
        ds_req    = '{start: 1'b1, op: DS_DIV, steps: 6'd30};
        ds_opa    = {numx, 34'd0};
        ds_dvs    = {17'd0, wq, 1'b0};
        state_nxt = ST_NXW;
      end
      ST_NXW: begin
        if (ds_done) state_nxt = ST_NYG;
      end
      ST_NYG: begin
        ds_req    = '{start: 1'b1, op: DS_DIV, steps: 6'd30};
        ds_opa    = {numy, 34'd0};
        ds_dvs    = {17'd0, hq, 1'b0};
        state_nxt = ST_NYW;
      end
      ST_NYW: begin
        if (ds_done) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        case (kind_r)
          KIND_PAN_SET: state_nxt = ST_IDLE;
          KIND_PAN:     state_nxt = ST_FIN;
          default:      state_nxt = ST_R2A;
        endcase
      end
      ST_R2A: begin
        mul_a = 33'(nx_r); mul_b = 33'(nx_r);
        state_nxt = ST_R2B;
      end
      ST_R2B: begin
        mul_a = 33'(ny_r); mul_b = 33'(ny_r);
        state_nxt = ST_R2C;
      end
      ST_R2C: state_nxt = ST_ZG;
      ST_ZG: begin
        if (acc_r <= 64'd8388608) begin
          ds_req = '{start: 1'b1, op: DS_SQRT, steps: 6'd25};
          ds_opa = {1'b0, sv, 38'd0};
        end else begin
          ds_req = '{start: 1'b1, op: DS_SQRT, steps: 6'd28};
          ds_opa = {acc_r[31:0], 32'd0};
        end
        state_nxt = ST_ZW;
      end
      ST_ZW: begin
        if (ds_done) state_nxt = sph_r ? ST_LIFT : ST_HG;
      end
      ST_HG: begin
        ds_req    = '{start: 1'b1, op: DS_DIV, steps: 6'd37};
        ds_opa    = {hnum, 27'd0};
        ds_dvs    = {nrm_r, 1'b0};
        state_nxt = ST_HW;
      end
      ST_HW: begin
        if (ds_done) state_nxt = ST_LIFT;
      end
      ST_LIFT: state_nxt = (kind_r == KIND_SPIN_SET) ? ST_IDLE : ST_CR0;
      ST_CR0: begin mul_a = 33'(say_r); mul_b = 33'(z_r);  state_nxt = ST_CR1; end
      ST_CR1: begin mul_a = 33'(saz_r); mul_b = 33'(ny_r); state_nxt = ST_CR2; end
      ST_CR2: begin mul_a = 33'(saz_r); mul_b = 33'(nx_r); state_nxt = ST_CR3; end
      ST_CR3: begin mul_a = 33'(sax_r); mul_b = 33'(z_r);  state_nxt = ST_CR4; end
      ST_CR4: begin mul_a = 33'(sax_r); mul_b = 33'(ny_r); state_nxt = ST_CR5; end
      ST_CR5: begin mul_a = 33'(say_r); mul_b = 33'(nx_r); state_nxt = ST_CR6; end
      ST_CR6: state_nxt = ST_SM0;
      ST_SM0: begin mul_a = 33'(hs_r); mul_b = cr_r[0]; state_nxt = ST_SM1; end
      ST_SM1: begin mul_a = 33'(hs_r); mul_b = cr_r[1]; state_nxt = ST_SM2; end
      ST_SM2: begin mul_a = 33'(hs_r); mul_b = cr_r[2]; state_nxt = ST_SM3; end
      ST_SM3: state_nxt = ST_SHF;
      ST_SHF: begin
        if (allz) state_nxt = ST_FIN;
        else if (!hi30 && hi29) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        mul_a = {3'd0, mag_r[idx_r[1:0]][29:0]};
        mul_b = {3'd0, mag_r[idx_r[1:0]][29:0]};
        if (idx_r == 3'd4) state_nxt = ST_NG;
      end
      ST_NG: begin
        ds_req    = '{start: 1'b1, op: DS_SQRT, steps: 6'd31};
        ds_opa    = {acc_r[61:0], 2'b00};
        state_nxt = ST_NW;
      end
      ST_NW: begin
        if (ds_done) state_nxt = ST_QG;
      end
      ST_QG: begin
        ds_req    = '{start: 1'b1, op: DS_DIV, steps: 6'd45};
        ds_opa    = {qnum, 19'd0};
        ds_dvs    = {1'b0, nrm_r};
        state_nxt = ST_QW;
      end
      ST_QW: begin
        if (ds_done) state_nxt = (idx_r == 3'd3) ? ST_FIN : ST_QG;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration and anchors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r  <= 14'd1;
      vh_r  <= 14'd1;
      hc_r  <= 16'sd16384;
      hs_r  <= '0;
      pax_r <= '0;
      pay_r <= '0;
      sax_r <= '0;
      say_r <= '0;
      saz_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_VIEW_W: vw_r <= cfg_data[13:0];
          CFG_VIEW_H: vh_r <= cfg_data[13:0];
          CFG_COS:    hc_r <= cfg_data;
          CFG_SIN:    hs_r <= cfg_data;
          default:    ;
        endcase
      end
      if (state_r == ST_DISP && (kind_r == KIND_PAN_SET || kind_r == KIND_PAN)) begin
        pax_r <= nx_r;
        pay_r <= ny_r;
      end
      if ((state_r == ST_LIFT && kind_r == KIND_SPIN_SET) || state_r == ST_SM3) begin
        sax_r <= nx_r;
        say_r <= ny_r;
        saz_r <= z_r;
      end
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kind_r <= in_kind;
        px_r   <= in_pos_x;
        py_r   <= in_pos_y;
      end
      ST_NXW: if (ds_done) nx_r <= sat_q(tx[16], ds_res);
      ST_NYW: if (ds_done) ny_r <= sat_q(ty[16], ds_res);
      ST_DISP: begin
        dx_r <= sat17({nx_r[15], nx_r} - {pax_r[15], pax_r});
        dy_r <= sat17({ny_r[15], ny_r} - {pay_r[15], pay_r});
      end
      ST_R2B: acc_r <= prod_r[63:0];
      ST_R2C: acc_r <= acc_r + prod_r[63:0];
      ST_ZG:  sph_r <= (acc_r <= 64'd8388608);
      ST_ZW: begin
        if (ds_done) begin
          if (sph_r) z_r <= 16'((ds_res + 48'd2048) >> 12);
          nrm_r <= ds_res[30:0];
        end
      end
      ST_HW:  if (ds_done) z_r <= ds_res[15:0];
      ST_CR1: tmp_r <= prod_r[32:0];
      ST_CR2: cr_r[0] <= tmp_r - prod_r[32:0];
      ST_CR3: tmp_r <= prod_r[32:0];
      ST_CR4: cr_r[1] <= tmp_r - prod_r[32:0];
      ST_CR5: tmp_r <= prod_r[32:0];
      ST_CR6: cr_r[2] <= tmp_r - prod_r[32:0];
      ST_SM1: begin mag_r[1] <= pmag; neg_r[1] <= pneg; end
      ST_SM2: begin mag_r[2] <= pmag; neg_r[2] <= pneg; end
      ST_SM3: begin
        mag_r[3] <= pmag;
        neg_r[3] <= pneg;
        mag_r[0] <= {7'd0, habs, 24'd0};
        neg_r[0] <= hc_r[15];
      end
      ST_SHF: begin
        // one bit of joint scaling per cycle
        if (allz) begin
          q_r[0] <= 16'sd16384;
          q_r[1] <= '0;
          q_r[2] <= '0;
          q_r[3] <= '0;
        end else if (hi30) begin
          for (int i = 0; i < 4; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!hi29) begin
          for (int i = 0; i < 4; i++) mag_r[i] <= mag_r[i] << 1;
        end else begin
          idx_r <= '0;
          acc_r <= '0;
        end
      end
      ST_SQ: begin
        if (idx_r != 3'd0) acc_r <= acc_r + prod_r[63:0];
        idx_r <= idx_r + 3'd1;
      end
      ST_NW: begin
        if (ds_done) begin
          nrm_r <= ds_res[30:0];
          idx_r <= '0;
        end
      end
      ST_QW: begin
        if (ds_done) begin
          q_r[idx_r[1:0]] <= neg_r[idx_r[1:0]] ? 16'(16'd0 - ds_res[15:0])
                                                : ds_res[15:0];
          idx_r <= idx_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      if (kind_r == KIND_PAN) begin
        okind_r <= RES_PAN;
        odx_r   <= dx_r;
        ody_r   <= dy_r;
        oqw_r   <= '0;
        oqx_r   <= '0;
        oqy_r   <= '0;
        oqz_r   <= '0;
      end else begin
        okind_r <= RES_SPIN;
        odx_r   <= '0;
        ody_r   <= '0;
        oqw_r   <= q_r[0];
        oqx_r   <= q_r[1];
        oqy_r   <= q_r[2];
        oqz_r   <= q_r[3];
      end
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_kind = okind_r;
  assign out_delta_x     = odx_r;
  assign out_delta_y     = ody_r;
  assign out_quat_w      = oqw_r;
  assign out_quat_x      = oqx_r;
  assign out_quat_y      = oqy_r;
  assign out_quat_z      = oqz_r;

  // The shared unit only runs while an event is in flight
  a_ds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ds_busy |-> state_r != ST_IDLE)
    else $error("divide/sqrt unit busy while idle");

  // An accepted event blocks the input on the next cycle
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after acceptance");

  // A new result only comes from the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result without completed event");

  // Unit quaternion components w and x stay within one
  a_quat_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RES_SPIN) |->
      (out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384 &&
       out_quat_x <= 16'sd16384 && out_quat_x >= -16'sd16384))
    else $error("quaternion component out of range");

endmodule
